@@ rtl/nebpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebpc_pkg
// Shared types and constants of the nibble escape byte pair codec.
// ----------------------------------------------------------------------------
package nebpc_pkg;

    localparam logic [7:0] ESC_HIGH    = 8'hF0;
    localparam logic [3:0] ESC_NIBBLE  = 4'hF;
    localparam logic [7:0] LOW_NIB     = 8'h0F;
    localparam logic [7:0] BIAS        = 8'd7;
    localparam logic [7:0] SMALL_LIMIT = 8'd15;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SECOND = 2'd1,
        PH_RAW    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       two_bytes;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ rtl/nebpc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebpc_front
// Accepts input bytes, tracks pair and code phase, and issues result entries.
// ----------------------------------------------------------------------------
module nebpc_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                data_byte,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      direction,
    input  nebpc_pkg::queue_status_t  status,
    output logic                      push,
    output nebpc_pkg::entry_t         push_entry
);

    nebpc_pkg::phase_t phase_reg;
    nebpc_pkg::phase_t phase_next;
    logic [7:0]        held_reg;
    logic [7:0]        held_next;
    logic              direction_reg;
    logic              accept;
    logic              cfg_write;
    logic [7:0]        biased;
    logic [7:0]        esc_first;
    logic [7:0]        plain_first;
    logic [7:0]        low_value;
    logic [7:0]        raw_value;
    logic              low_is_esc;
    logic              high_is_esc;
    logic [7:0]        pair_high;

    assign in_ready  = !status.full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign cfg_write = cfg_valid && cfg_ready;

    assign biased      = data_byte + nebpc_pkg::BIAS;
    assign pair_high   = {held_reg[3:0], 4'h0};
    assign esc_first   = {held_reg[3:0], data_byte[7:4]} - nebpc_pkg::BIAS;
    assign plain_first = {4'h0, data_byte[7:4]} - nebpc_pkg::BIAS;
    assign low_value   = (data_byte & nebpc_pkg::LOW_NIB) - nebpc_pkg::BIAS;
    assign raw_value   = data_byte - nebpc_pkg::BIAS;
    assign low_is_esc  = (data_byte[3:0] == nebpc_pkg::ESC_NIBBLE);
    assign high_is_esc = (data_byte[7:4] == nebpc_pkg::ESC_NIBBLE);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (direction_reg == nebpc_pkg::DIR_ENCODE)
        begin
            if (phase_reg != nebpc_pkg::PH_SECOND)
            begin
                held_next  = biased;
                phase_next = nebpc_pkg::PH_SECOND;
            end
            else
            begin
                phase_next = nebpc_pkg::PH_LEAD;
            end
        end
        else
        begin
            case (phase_reg)
                nebpc_pkg::PH_SECOND:
                begin
                    phase_next = low_is_esc ? nebpc_pkg::PH_RAW : nebpc_pkg::PH_LEAD;
                end
                nebpc_pkg::PH_RAW:
                begin
                    phase_next = nebpc_pkg::PH_LEAD;
                end
                default:
                begin
                    if (high_is_esc)
                    begin
                        held_next  = data_byte;
                        phase_next = nebpc_pkg::PH_SECOND;
                    end
                    else
                    begin
                        phase_next = low_is_esc ? nebpc_pkg::PH_RAW : nebpc_pkg::PH_LEAD;
                    end
                end
            endcase
        end
    end

    // result entry
    always_comb
    begin
        push                   = 1'b0;
        push_entry.first_byte  = raw_value;
        push_entry.second_byte = low_value;
        push_entry.two_bytes   = 1'b0;
        if (direction_reg == nebpc_pkg::DIR_ENCODE)
        begin
            if (phase_reg != nebpc_pkg::PH_SECOND)
            begin
                push                  = accept && (biased >= nebpc_pkg::SMALL_LIMIT);
                push_entry.first_byte = nebpc_pkg::ESC_HIGH | {4'h0, biased[7:4]};
            end
            else if (biased < nebpc_pkg::SMALL_LIMIT)
            begin
                push                  = accept;
                push_entry.first_byte = pair_high | biased;
            end
            else
            begin
                push                   = accept;
                push_entry.first_byte  = pair_high | nebpc_pkg::LOW_NIB;
                push_entry.second_byte = biased;
                push_entry.two_bytes   = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                nebpc_pkg::PH_SECOND:
                begin
                    push                  = accept;
                    push_entry.first_byte = esc_first;
                    push_entry.two_bytes  = !low_is_esc;
                end
                nebpc_pkg::PH_RAW:
                begin
                    push                  = accept;
                    push_entry.first_byte = raw_value;
                end
                default:
                begin
                    push                  = accept && !high_is_esc;
                    push_entry.first_byte = plain_first;
                    push_entry.two_bytes  = !low_is_esc;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= nebpc_pkg::PH_LEAD;
            held_reg      <= 8'h00;
            direction_reg <= nebpc_pkg::DIR_ENCODE;
        end
        else if (cfg_write)
        begin
            phase_reg     <= nebpc_pkg::PH_LEAD;
            held_reg      <= 8'h00;
            direction_reg <= direction;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

@@ rtl/nebpc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebpc_queue
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module nebpc_queue
#(
    parameter int DEPTH = nebpc_pkg::QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  nebpc_pkg::entry_t         push_entry,
    input  logic                      pop,
    output nebpc_pkg::entry_t         head,
    output nebpc_pkg::queue_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    nebpc_pkg::entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign head         = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/nebpc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nebpc_back
// Drains queued entries to the output, one result byte a cycle unless stalled.
// ----------------------------------------------------------------------------
module nebpc_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  nebpc_pkg::entry_t         head,
    input  nebpc_pkg::queue_status_t  status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic                      last_of_run
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       last_reg;
    logic       last_next;
    logic       pending_reg;
    logic       pending_next;
    logic       load;

    assign load        = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        pending_next   = pending_reg;
        pop            = 1'b0;
        if (load)
        begin
            if (pending_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = head.second_byte;
                last_next      = 1'b1;
                pending_next   = 1'b0;
                pop            = 1'b1;
            end
            else if (!status.empty)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = head.first_byte;
                last_next      = !head.two_bytes;
                pending_next   = head.two_bytes;
                pop            = !head.two_bytes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pending_reg   <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

endmodule

@@ rtl/nibble_escape_byte_pair_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_escape_byte_pair_codec
// Byte pair nibble escape encoder and decoder, selected by the direction
// register.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the result queue has room; each
// transfer yields zero, one or two result bytes. Results leave the single
// output register at one byte per cycle while the receiver is ready, so a
// stream in which every input gives two bytes is held back by the output
// once the queue (QUEUE_DEPTH entries, one per input that gives a result) has
// filled. The first result of an input passes through its queue entry and
// then the output register before it is offered. The direction register
// is written through the cfg channel, which is always ready; a write clears
// any partial pair or partial code, and must only happen while the block is
// idle. A trailing unpaired encode byte gives only its escape lead, if any.
// ----------------------------------------------------------------------------
module nibble_escape_byte_pair_codec
#(
    parameter int QUEUE_DEPTH = nebpc_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       direction
);

    nebpc_pkg::queue_status_t status;
    nebpc_pkg::entry_t        push_entry;
    nebpc_pkg::entry_t        head;
    logic                     push;
    logic                     pop;

    nebpc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .direction  (direction),
        .status     (status),
        .push       (push),
        .push_entry (push_entry)
    );

    nebpc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    nebpc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

@@ tb/nibble_escape_byte_pair_codec_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nibble_escape_byte_pair_codec_tb
// Self-checking bench for the nibble escape byte pair codec. Byte transfers
// go into a tracker that encodes or decodes them with its own phase and held
// byte and queues the code or restored bytes due. Each output transfer is
// checked in order against that queue. A short directed run covers the
// special cases: small and escaped pairs, every decoder lead form, a dropped
// trailing byte and a direction change mid-stream. Random phases in both
// directions follow, with random gaps and stalls on both sides, one long
// receiver hold-off and one full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module nibble_escape_byte_pair_codec_tb;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_ITEMS    = 240;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } code_byte_t;

    class codec_byte_tracker;
        logic              dir;
        nebpc_pkg::phase_t phase;
        logic [7:0]        held;
        code_byte_t        expected_bytes[$];
        logic [7:0]        run_buf[3];
        int                run_len;
        int                errors;
        int                reported;

        function new();
            dir      = nebpc_pkg::DIR_ENCODE;
            phase    = nebpc_pkg::PH_LEAD;
            held     = '0;
            run_len  = 0;
            errors   = 0;
            reported = 0;
        endfunction

        function void set_direction(logic value);
            dir   = value;
            phase = nebpc_pkg::PH_LEAD;
            held  = '0;
        endfunction

        function void emit(logic [7:0] value);
            run_buf[run_len] = value;
            run_len++;
        endfunction

        function void close_pair(logic [3:0] low);
            if (low == nebpc_pkg::ESC_NIBBLE)
            begin
                phase = nebpc_pkg::PH_RAW;
            end
            else
            begin
                emit({4'h0, low} - nebpc_pkg::BIAS);
                phase = nebpc_pkg::PH_LEAD;
            end
        endfunction

        function void take_input_byte(logic [7:0] d);
            logic [7:0] v;
            code_byte_t item;
            run_len = 0;
            if (dir == nebpc_pkg::DIR_ENCODE)
            begin
                v = d + nebpc_pkg::BIAS;
                if (phase != nebpc_pkg::PH_SECOND)
                begin
                    held = v;
                    if (v >= nebpc_pkg::SMALL_LIMIT)
                        emit(nebpc_pkg::ESC_HIGH | (v >> 4));
                    phase = nebpc_pkg::PH_SECOND;
                end
                else
                begin
                    if (v < nebpc_pkg::SMALL_LIMIT)
                    begin
                        emit({held[3:0], v[3:0]});
                    end
                    else
                    begin
                        emit({held[3:0], nebpc_pkg::ESC_NIBBLE});
                        emit(v);
                    end
                    phase = nebpc_pkg::PH_LEAD;
                end
            end
            else
            begin
                case (phase)
                    nebpc_pkg::PH_SECOND:
                    begin
                        emit({held[3:0], d[7:4]} - nebpc_pkg::BIAS);
                        close_pair(d[3:0]);
                    end
                    nebpc_pkg::PH_RAW:
                    begin
                        emit(d - nebpc_pkg::BIAS);
                        phase = nebpc_pkg::PH_LEAD;
                    end
                    default:
                    begin
                        if (d[7:4] == nebpc_pkg::ESC_NIBBLE)
                        begin
                            held  = d;
                            phase = nebpc_pkg::PH_SECOND;
                        end
                        else
                        begin
                            emit({4'h0, d[7:4]} - nebpc_pkg::BIAS);
                            close_pair(d[3:0]);
                        end
                    end
                endcase
            end
            for (int i = 0; i < run_len; i++)
            begin
                item.value = run_buf[i];
                item.last  = (i == run_len - 1);
                expected_bytes.push_back(item);
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (reported < REPORT_LIMIT)
            begin
                reported++;
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endfunction

        function void check_out_byte(logic [7:0] value, logic last);
            code_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                flag($sformatf("unexpected byte %02h last %0b", value, last));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (want.value !== value || want.last !== last)
                    flag($sformatf("byte %02h last %0b, expected byte %02h last %0b",
                                   value, last, want.value, want.last));
            end
        endfunction

        function void close_out();
            code_byte_t want;
            while (expected_bytes.size() > 0)
            begin
                want = expected_bytes.pop_front();
                flag($sformatf("missing byte %02h last %0b", want.value, want.last));
            end
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte     = '0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic       cfg_direction = nebpc_pkg::DIR_ENCODE;

    bit no_idle      = 1'b0;
    bit hold_off_req = 1'b0;
    int idle_cycles  = 0;
    int sent_items   = 0;

    codec_byte_tracker tracker;

    nibble_escape_byte_pair_codec i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .direction   (cfg_direction)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_out_byte(out_byte, last_of_run);
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] random_byte(logic dir);
        logic [3:0] hi;
        logic [3:0] lo;
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        if (dir == nebpc_pkg::DIR_ENCODE)
        begin
            if ($urandom_range(0, 2) == 0)
                return 8'($urandom_range(248, 263));
            return 8'($urandom_range(0, 255));
        end
        hi = ($urandom_range(0, 3) == 0) ? nebpc_pkg::ESC_NIBBLE : 4'($urandom_range(0, 14));
        lo = ($urandom_range(0, 3) == 0) ? nebpc_pkg::ESC_NIBBLE : 4'($urandom_range(0, 14));
        return {hi, lo};
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_input_byte(value);
        sent_items++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic value);
        wait_idle();
        cfg_valid     <= 1'b1;
        cfg_direction <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tracker.set_direction(value);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] enc_seq[11] = '{8'h00, 8'h00, 8'hFF, 8'h07, 8'h08, 8'hFF,
                                    8'h03, 8'hC8, 8'h80, 8'hF8, 8'h64};
        logic [7:0] dec_seq[12] = '{8'h12, 8'h3F, 8'hFF, 8'hF5, 8'h6A, 8'hF0,
                                    8'h0F, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'hF9};
        int   phase_no;
        int   count;
        logic dir;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_direction(nebpc_pkg::DIR_ENCODE);
        foreach (enc_seq[i])
            send_byte(enc_seq[i]);
        write_direction(nebpc_pkg::DIR_DECODE);
        foreach (dec_seq[i])
            send_byte(dec_seq[i]);
        write_direction(nebpc_pkg::DIR_DECODE);
        send_byte(8'h4F);
        write_direction(nebpc_pkg::DIR_ENCODE);

        phase_no   = 0;
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            dir = (phase_no < 2) ? phase_no[0] : 1'($urandom_range(0, 1));
            write_direction(dir);
            no_idle = (phase_no % 4 == 3);
            count   = (phase_no == 0) ? 30 : $urandom_range(15, 45);
            for (int k = 0; k < count; k++)
            begin
                if (phase_no == 0 && k == 5)
                begin
                    hold_off_req = 1'b1;
                    no_idle      = 1'b1;
                end
                if (phase_no == 0 && k == 20)
                    no_idle = 1'b0;
                if (phase_no == 1 && k == count / 2)
                    wait_idle();
                send_byte(random_byte(dir));
            end
            phase_no++;
        end

        wait_idle();
        tracker.close_out();
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
